// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the grid path stack.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gps_pkg.sv =====
// Package of the grid path stack: sequencer states, command and status codes,
// register indexes and field widths. It depends on nothing else.
package gps_pkg;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_PUSH_RD,
    S_PUSH_EV,
    S_WALK,
    S_DONE
  } state_t;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_TRUNC = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] STAT_ADDED = 2'd0;
  localparam logic [1:0] STAT_CYCLE = 2'd1;
  localparam logic [1:0] STAT_OUT   = 2'd2;
  localparam logic [1:0] STAT_DONE  = 2'd3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam int DIM_W       = 6;
  localparam int COORD_W     = 7;
  localparam int KEEP_W      = 11;
  localparam int CYC_W       = 10;
  localparam int PLEN_W      = 11;
  localparam int ENTRY_W     = 2 * DIM_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

endpackage

// ===== rtl/core/gps_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
module gps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gps_cell_unit.sv =====
// Shared cell unit: clamps the grid size, checks a cell against the grid,
// forms its bitmap address and the clamped grid area. It depends on gps_pkg.
module gps_cell_unit #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic signed [gps_pkg::COORD_W-1:0]      row,
  input  logic signed [gps_pkg::COORD_W-1:0]      col,
  input  logic [gps_pkg::DIM_W-1:0]               grid_width,
  input  logic [gps_pkg::DIM_W-1:0]               grid_height,
  output logic                                    in_grid,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]    addr,
  output logic [2*gps_pkg::DIM_W-1:0]             area
);

  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

  logic [gps_pkg::DIM_W-1:0] w_eff;
  logic [gps_pkg::DIM_W-1:0] h_eff;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = gps_pkg::DIM_W'(1);
    end else if (int'(grid_width) > MAX_COLS) begin
      w_eff = gps_pkg::DIM_W'(MAX_COLS);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = gps_pkg::DIM_W'(1);
    end else if (int'(grid_height) > MAX_ROWS) begin
      h_eff = gps_pkg::DIM_W'(MAX_ROWS);
    end else begin
      h_eff = grid_height;
    end
  end

  assign area = (2*gps_pkg::DIM_W)'(w_eff) * (2*gps_pkg::DIM_W)'(h_eff);

  assign in_grid = !row[gps_pkg::COORD_W-1] && !col[gps_pkg::COORD_W-1]
                   && (row[gps_pkg::DIM_W-1:0] < h_eff)
                   && (col[gps_pkg::DIM_W-1:0] < w_eff);

  assign addr = AW'(int'(row[gps_pkg::DIM_W-1:0]) * MAX_COLS
                    + int'(col[gps_pkg::DIM_W-1:0]));

endmodule

// ===== rtl/core/grid_path_stack_with_cycle_check.sv =====
// Top level of the grid path stack with cycle check: sequencer, registers and
// RAM instances. It depends on gps_pkg, gps_ram, gps_cell_unit and
// assert_macros.svh.
//
// A path of grid cells is held as a stack in RAM, with a visited bitmap and a
// position table, each MAX_ROWS*MAX_COLS entries deep. After reset the block
// clears the bitmap, one entry per cycle, with s_tready low; configuration
// writes are taken during that time. A push reads the bitmap and position RAMs
// as the request is taken, and checks and adds the cell once their registered
// read is ready. Truncate and clear go through the dispatch state and walk the
// dropped path entries through the single path RAM read port, one entry per
// cycle. The first request after a grid register write first walks the whole
// path to recount the visited cells inside the grid, then goes through the
// dispatch state, and a push also through its RAM read state. The result sits
// in an output register; a finished request waits until that register is free
// or being handed over, and the next request can be taken while the previous
// result still waits to be handed over.
`include "assert_macros.svh"

module grid_path_stack_with_cycle_check #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [gps_pkg::DIM_W-1:0]          cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: command, cell_row, cell_col, keep_index, zero fill.
  input  logic [gps_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Fields from bit 0: status, cycle_index, path_length, all_visited.
  output logic [gps_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int LW = $clog2(CELL_COUNT + 1);

  gps_pkg::state_t state, state_next;

  logic [gps_pkg::DIM_W-1:0]          grid_width;
  logic [gps_pkg::DIM_W-1:0]          grid_height;
  logic [1:0]                         cmd_q;
  logic signed [gps_pkg::COORD_W-1:0] row_q;
  logic signed [gps_pkg::COORD_W-1:0] col_q;
  logic signed [gps_pkg::KEEP_W-1:0]  keep_q;
  logic [LW-1:0]                      len;
  logic [LW-1:0]                      in_count;
  logic [LW-1:0]                      walk_idx;
  logic [LW-1:0]                      walk_end;
  logic                               rd_pend;
  logic                               walk_recount;
  logic                               stale;
  logic [1:0]                         res_status;
  logic [gps_pkg::CYC_W-1:0]          res_cyc;
  logic [1:0]                         out_status;
  logic [gps_pkg::CYC_W-1:0]          out_cyc;
  logic [gps_pkg::PLEN_W-1:0]         out_len;
  logic                               out_all;

  logic                               accept;
  logic                               out_free;
  logic                               walk_done;
  logic [1:0]                         in_cmd;
  logic [LW-1:0]                      new_len;

  logic signed [gps_pkg::COORD_W-1:0] u_row;
  logic signed [gps_pkg::COORD_W-1:0] u_col;
  logic                               u_in_grid;
  logic [AW-1:0]                      u_addr;
  logic [2*gps_pkg::DIM_W-1:0]        u_area;

  logic                               vis_we;
  logic [AW-1:0]                      vis_waddr;
  logic                               vis_wdata;
  logic                               vis_rdata;
  logic [AW-1:0]                      pos_rdata;
  logic [gps_pkg::ENTRY_W-1:0]        path_rdata;
  logic                               add_cell;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign walk_done = (walk_idx == walk_end) && !rd_pend;
  assign in_cmd    = s_tdata[1:0];
  assign add_cell  = (state == gps_pkg::S_PUSH_EV) && u_in_grid && !vis_rdata
                     && (int'(len) < CELL_COUNT);

  always_comb begin
    if (keep_q[gps_pkg::KEEP_W-1] || cmd_q == gps_pkg::CMD_CLEAR) begin
      new_len = '0;
    end else if (int'(keep_q[gps_pkg::KEEP_W-2:0]) + 1 < int'(len)) begin
      new_len = LW'(int'(keep_q[gps_pkg::KEEP_W-2:0]) + 1);
    end else begin
      new_len = len;
    end
  end

  always_comb begin
    case (state)
      gps_pkg::S_IDLE: begin
        u_row = s_tdata[8:2];
        u_col = s_tdata[15:9];
      end
      gps_pkg::S_WALK: begin
        u_row = {1'b0, path_rdata[gps_pkg::ENTRY_W-1:gps_pkg::DIM_W]};
        u_col = {1'b0, path_rdata[gps_pkg::DIM_W-1:0]};
      end
      default: begin
        u_row = row_q;
        u_col = col_q;
      end
    endcase
  end

  gps_cell_unit #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_cell (
    .row        (u_row),
    .col        (u_col),
    .grid_width (grid_width),
    .grid_height(grid_height),
    .in_grid    (u_in_grid),
    .addr       (u_addr),
    .area       (u_area)
  );

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = u_addr;
    vis_wdata = 1'b0;
    case (state)
      gps_pkg::S_INIT: begin
        vis_we    = 1'b1;
        vis_waddr = walk_idx[AW-1:0];
      end
      gps_pkg::S_PUSH_EV: begin
        vis_we    = add_cell;
        vis_wdata = 1'b1;
      end
      gps_pkg::S_WALK: begin
        vis_we = rd_pend && !walk_recount;
      end
      default: begin
        vis_we = 1'b0;
      end
    endcase
  end

  gps_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_visited (
    .clk  (clk),
    .we   (vis_we),
    .waddr(vis_waddr),
    .wdata(vis_wdata),
    .raddr(u_addr),
    .rdata(vis_rdata)
  );

  gps_ram #(.WIDTH(AW), .DEPTH(CELL_COUNT)) u_position (
    .clk  (clk),
    .we   (add_cell),
    .waddr(u_addr),
    .wdata(len[AW-1:0]),
    .raddr(u_addr),
    .rdata(pos_rdata)
  );

  gps_ram #(.WIDTH(gps_pkg::ENTRY_W), .DEPTH(CELL_COUNT)) u_path (
    .clk  (clk),
    .we   (add_cell),
    .waddr(len[AW-1:0]),
    .wdata({row_q[gps_pkg::DIM_W-1:0], col_q[gps_pkg::DIM_W-1:0]}),
    .raddr(walk_idx[AW-1:0]),
    .rdata(path_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      gps_pkg::S_INIT: begin
        if (walk_idx == LW'(CELL_COUNT - 1)) begin
          state_next = gps_pkg::S_IDLE;
        end
      end
      gps_pkg::S_IDLE: begin
        if (accept) begin
          if (stale) begin
            state_next = gps_pkg::S_WALK;
          end else if (in_cmd == gps_pkg::CMD_PUSH) begin
            state_next = gps_pkg::S_PUSH_EV;
          end else begin
            state_next = gps_pkg::S_DISPATCH;
          end
        end
      end
      gps_pkg::S_DISPATCH: begin
        case (cmd_q)
          gps_pkg::CMD_PUSH:  state_next = gps_pkg::S_PUSH_RD;
          gps_pkg::CMD_TRUNC: state_next = gps_pkg::S_WALK;
          gps_pkg::CMD_CLEAR: state_next = gps_pkg::S_WALK;
          default:            state_next = gps_pkg::S_DONE;
        endcase
      end
      gps_pkg::S_PUSH_RD: state_next = gps_pkg::S_PUSH_EV;
      gps_pkg::S_PUSH_EV: state_next = gps_pkg::S_DONE;
      gps_pkg::S_WALK: begin
        if (walk_done) begin
          state_next = walk_recount ? gps_pkg::S_DISPATCH : gps_pkg::S_DONE;
        end
      end
      gps_pkg::S_DONE: begin
        if (out_free) begin
          state_next = gps_pkg::S_IDLE;
        end
      end
      default: state_next = gps_pkg::S_INIT;
    endcase
  end

  always_comb begin
    s_tready = (state == gps_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gps_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gps_pkg::DIM_RESET;
      grid_height <= gps_pkg::DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == gps_pkg::REG_GRID_WIDTH) begin
        grid_width <= cfg_wdata;
      end else begin
        grid_height <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale <= 1'b0;
    end else if (cfg_we) begin
      stale <= 1'b1;
    end else if (state == gps_pkg::S_WALK && walk_done && walk_recount) begin
      stale <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      in_count     <= '0;
      walk_idx     <= '0;
      walk_end     <= '0;
      rd_pend      <= 1'b0;
      walk_recount <= 1'b0;
    end else begin
      case (state)
        gps_pkg::S_INIT: begin
          walk_idx <= walk_idx + 1'b1;
        end
        gps_pkg::S_IDLE: begin
          if (accept && stale) begin
            walk_idx     <= '0;
            walk_end     <= len;
            walk_recount <= 1'b1;
            in_count     <= '0;
            rd_pend      <= 1'b0;
          end
        end
        gps_pkg::S_DISPATCH: begin
          if (cmd_q == gps_pkg::CMD_TRUNC || cmd_q == gps_pkg::CMD_CLEAR) begin
            walk_idx     <= new_len;
            walk_end     <= len;
            walk_recount <= 1'b0;
            rd_pend      <= 1'b0;
            len          <= new_len;
          end
        end
        gps_pkg::S_PUSH_EV: begin
          if (add_cell) begin
            len      <= len + 1'b1;
            in_count <= in_count + 1'b1;
          end
        end
        gps_pkg::S_WALK: begin
          rd_pend <= (walk_idx != walk_end);
          if (walk_idx != walk_end) begin
            walk_idx <= walk_idx + 1'b1;
          end
          if (rd_pend) begin
            if (walk_recount) begin
              in_count <= in_count + LW'(u_in_grid);
            end else begin
              in_count <= in_count - LW'(u_in_grid);
            end
          end
        end
        default: begin
          rd_pend <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= in_cmd;
      row_q  <= s_tdata[8:2];
      col_q  <= s_tdata[15:9];
      keep_q <= s_tdata[26:16];
    end
    if (state == gps_pkg::S_DISPATCH) begin
      res_status <= gps_pkg::STAT_DONE;
      res_cyc    <= '0;
    end
    if (state == gps_pkg::S_PUSH_EV) begin
      if (!u_in_grid) begin
        res_status <= gps_pkg::STAT_OUT;
        res_cyc    <= '0;
      end else if (vis_rdata) begin
        res_status <= gps_pkg::STAT_CYCLE;
        res_cyc    <= gps_pkg::CYC_W'(pos_rdata);
      end else if (add_cell) begin
        res_status <= gps_pkg::STAT_ADDED;
        res_cyc    <= '0;
      end else begin
        res_status <= gps_pkg::STAT_OUT;
        res_cyc    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == gps_pkg::S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gps_pkg::S_DONE && out_free) begin
      out_status <= res_status;
      out_cyc    <= res_cyc;
      out_len    <= gps_pkg::PLEN_W'(len);
      out_all    <= (int'(in_count) == int'(u_area));
    end
  end

  assign m_tdata = {out_all, out_len, out_cyc, out_status};

  `ASSERT_SAME(a_len_bound, 1'b1, int'(len) <= CELL_COUNT, "Path length beyond cell count.")
  `ASSERT_SAME(a_count_le_len, state == gps_pkg::S_IDLE && !stale, in_count <= len,
    "Visited count in grid exceeds path length.")
  `ASSERT_NEXT(a_push_grows, add_cell, len == $past(len) + 1'b1,
    "Added cell did not grow the path.")
  `ASSERT_NEXT(a_result_out, state == gps_pkg::S_DONE && out_free, m_tvalid,
    "Finished request produced no result.")

endmodule
